### hdl/dnsa_pkg.sv
// ----------------------------------------------------------------------------
// dnsa_pkg
// Types and constants for the DNS response A-record extractor.
// ----------------------------------------------------------------------------
package dnsa_pkg;

    localparam int MAX_MESSAGE = 512;

    localparam int POS_W   = 10;
    localparam int QLEN_W  = 9;
    localparam int STAT_W  = 3;
    localparam int FIELD_W = 4;

    localparam int HDR_LEN = 12;

    // header byte offsets
    localparam logic [POS_W-1:0] HDR_FLAGS_HI = POS_W'(2);
    localparam logic [POS_W-1:0] HDR_FLAGS_LO = POS_W'(3);
    localparam logic [POS_W-1:0] HDR_ANCNT_HI = POS_W'(6);
    localparam logic [POS_W-1:0] HDR_ANCNT_LO = POS_W'(7);
    localparam logic [POS_W-1:0] HDR_LAST     = POS_W'(11);

    // fixed answer fields: type, class, ttl, rdlength
    localparam logic [FIELD_W-1:0] FX_TYPE_HI  = FIELD_W'(0);
    localparam logic [FIELD_W-1:0] FX_TYPE_LO  = FIELD_W'(1);
    localparam logic [FIELD_W-1:0] FX_CLASS_HI = FIELD_W'(2);
    localparam logic [FIELD_W-1:0] FX_CLASS_LO = FIELD_W'(3);
    localparam logic [FIELD_W-1:0] FX_RDLEN_HI = FIELD_W'(8);
    localparam logic [FIELD_W-1:0] FX_RDLEN_LO = FIELD_W'(9);
    localparam logic [FIELD_W-1:0] FX_END      = FIELD_W'(10);
    localparam logic [FIELD_W-1:0] ADDR_BYTES  = FIELD_W'(4);

    localparam logic [15:0] RR_TYPE_A  = 16'h0001;
    localparam logic [15:0] RR_CLASS_IN = 16'h0001;
    localparam logic [15:0] A_RDLEN    = 16'h0004;

    localparam logic [15:0] FLAG_QR    = 16'h8000;
    localparam logic [15:0] FLAG_RCODE = 16'h000f;
    localparam logic [7:0]  PTR_MASK   = 8'hc0;

    localparam logic [QLEN_W-1:0] QLEN_RESET = QLEN_W'(17);

    typedef enum logic [STAT_W-1:0] {
        ST_FOUND      = 3'd0,
        ST_NO_A       = 3'd1,
        ST_BAD_LEN    = 3'd2,
        ST_ERR_FLAGS  = 3'd3,
        ST_TRUNC_Q    = 3'd4,
        ST_MALFORMED  = 3'd5,
        ST_TRUNC_DATA = 3'd6
    } status_t;

    typedef enum logic [10:0] {
        PH_PREFIX_HI = 11'b000_0000_0001,
        PH_PREFIX_LO = 11'b000_0000_0010,
        PH_HEADER    = 11'b000_0000_0100,
        PH_QUESTION  = 11'b000_0000_1000,
        PH_NAME      = 11'b000_0001_0000,
        PH_LABEL     = 11'b000_0010_0000,
        PH_POINTER   = 11'b000_0100_0000,
        PH_FIXED     = 11'b000_1000_0000,
        PH_ADDR      = 11'b001_0000_0000,
        PH_RDATA     = 11'b010_0000_0000,
        PH_DRAIN     = 11'b100_0000_0000
    } phase_t;

endpackage

### hdl/dns_response_a_record_extract.sv
// ----------------------------------------------------------------------------
// dns_response_a_record_extract
// Walks a DNS-over-TCP response byte by byte and reports the first IN A
// address, or why none was found.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one response byte per request, starting with the 2-byte
//   big-endian length prefix, then the message, then the next prefix.
//   m_axis carries one status per message: found, no A record, or an error.
//   cfg_* writes the question section length; write it only while idle.
// Timing:
//   One byte per cycle unless a result waits on a stalled receiver; each
//   accepted byte updates the parse state. The result lands in the output
//   register on the edge that accepts the deciding byte, so it shows in the next cycle.
// Reset:
//   Parser waits for a length prefix, output empty, question length 17.
// Stall:
//   s_axis_tready stays high while m_axis_tready is high; with the receiver
//   stalled and a result pending, input stops until the result is taken.
// ----------------------------------------------------------------------------
module dns_response_a_record_extract
    import dnsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] response_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [2:0] status, [34:3] ipv4_address,
                                        // [50:35] response_flags, rest zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [QLEN_W-1:0] cfg_data  // [8:0] question_length
);

    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    byte_pos_reg, byte_pos_next;
    logic [POS_W-1:0]    msg_len_reg, msg_len_next;
    logic [15:0]         answers_reg, answers_next;
    logic [15:0]         flags_reg, flags_next;
    logic [7:0]          skip_reg, skip_next;
    logic [FIELD_W-1:0]  field_pos_reg, field_pos_next;
    logic [15:0]         rec_type_reg, rec_type_next;
    logic [15:0]         rec_class_reg, rec_class_next;
    logic [15:0]         data_len_reg, data_len_next;
    logic [31:0]         addr_reg, addr_next;
    logic                reported_reg, reported_next;
    logic [QLEN_W-1:0]   qlen_reg;

    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [31:0]         out_addr_reg;
    logic [15:0]         out_flags_reg;

    logic                accept;
    logic                res_fire;
    status_t             res_status;
    logic [31:0]         res_addr;
    logic                in_prefix;
    logic [7:0]          b;
    logic [POS_W:0]      p_inc;
    logic [POS_W:0]      q_end;
    logic [15:0]         len_full;
    logic [POS_W-1:0]    remaining;
    logic [15:0]         ans_dec;

    assign b         = s_axis_tdata;
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign p_inc     = {1'b0, byte_pos_reg} + (POS_W+1)'(1);
    assign q_end     = (POS_W+1)'(HDR_LEN) + (POS_W+1)'(qlen_reg);
    assign len_full  = {msg_len_reg[7:0], b};
    assign remaining = msg_len_reg - p_inc[POS_W-1:0];
    assign ans_dec   = answers_reg - 16'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        byte_pos_next  = byte_pos_reg;
        msg_len_next   = msg_len_reg;
        answers_next   = answers_reg;
        flags_next     = flags_reg;
        skip_next      = skip_reg;
        field_pos_next = field_pos_reg;
        rec_type_next  = rec_type_reg;
        rec_class_next = rec_class_reg;
        data_len_next  = data_len_reg;
        addr_next      = addr_reg;
        reported_next  = reported_reg;
        res_fire       = 1'b0;
        res_status     = ST_FOUND;
        res_addr       = 32'd0;
        in_prefix      = 1'b0;

        case (phase_reg)
            PH_PREFIX_HI:
            begin
                in_prefix     = 1'b1;
                msg_len_next  = POS_W'(b);
                flags_next    = 16'd0;
                answers_next  = 16'd0;
                reported_next = 1'b0;
                byte_pos_next = '0;
                phase_next    = PH_PREFIX_LO;
            end
            PH_PREFIX_LO:
            begin
                in_prefix = 1'b1;
                if (len_full < 16'(HDR_LEN) || len_full > 16'(MAX_MESSAGE))
                begin
                    msg_len_next  = '0;
                    res_fire      = 1'b1;
                    res_status    = ST_BAD_LEN;
                    reported_next = 1'b1;
                    phase_next    = PH_PREFIX_HI;
                end
                else
                begin
                    msg_len_next  = len_full[POS_W-1:0];
                    byte_pos_next = '0;
                    phase_next    = PH_HEADER;
                end
            end
            PH_HEADER:
            begin
                case (byte_pos_reg)
                    HDR_FLAGS_HI: flags_next = {b, 8'h00};
                    HDR_FLAGS_LO:
                    begin
                        flags_next = {flags_reg[15:8], b};
                        if ((flags_next & FLAG_QR) == 16'd0 ||
                            (flags_next & FLAG_RCODE) != 16'd0)
                        begin
                            res_fire   = 1'b1;
                            res_status = ST_ERR_FLAGS;
                        end
                        else if (q_end > {1'b0, msg_len_reg})
                        begin
                            res_fire   = 1'b1;
                            res_status = ST_TRUNC_Q;
                        end
                    end
                    HDR_ANCNT_HI: answers_next = {b, 8'h00};
                    HDR_ANCNT_LO:
                    begin
                        answers_next = {answers_reg[15:8], b};
                        if (answers_next == 16'd0)
                        begin
                            res_fire   = 1'b1;
                            res_status = ST_NO_A;
                        end
                    end
                    HDR_LAST:
                        phase_next = (qlen_reg == '0) ? PH_NAME : PH_QUESTION;
                    default: ;
                endcase
            end
            PH_QUESTION:
            begin
                if (p_inc >= q_end)
                    phase_next = PH_NAME;
            end
            PH_NAME:
            begin
                if (b == 8'd0)
                begin
                    field_pos_next = '0;
                    phase_next     = PH_FIXED;
                end
                else if ((b & PTR_MASK) == PTR_MASK)
                    phase_next = PH_POINTER;
                else
                begin
                    skip_next  = b;
                    phase_next = PH_LABEL;
                end
            end
            PH_LABEL:
            begin
                skip_next = skip_reg - 8'd1;
                if (skip_next == 8'd0)
                    phase_next = PH_NAME;
            end
            PH_POINTER:
            begin
                field_pos_next = '0;
                phase_next     = PH_FIXED;
            end
            PH_FIXED:
            begin
                case (field_pos_reg)
                    FX_TYPE_HI:  rec_type_next  = {b, 8'h00};
                    FX_TYPE_LO:  rec_type_next  = {rec_type_reg[15:8], b};
                    FX_CLASS_HI: rec_class_next = {b, 8'h00};
                    FX_CLASS_LO: rec_class_next = {rec_class_reg[15:8], b};
                    FX_RDLEN_HI: data_len_next  = {b, 8'h00};
                    FX_RDLEN_LO: data_len_next  = {data_len_reg[15:8], b};
                    default: ;
                endcase
                field_pos_next = field_pos_reg + FIELD_W'(1);
                if (field_pos_next == FX_END)
                begin
                    if (data_len_next > 16'(remaining))
                    begin
                        res_fire   = 1'b1;
                        res_status = ST_TRUNC_DATA;
                    end
                    else if (rec_type_reg == RR_TYPE_A && rec_class_reg == RR_CLASS_IN &&
                             data_len_next == A_RDLEN)
                    begin
                        addr_next      = 32'd0;
                        field_pos_next = '0;
                        phase_next     = PH_ADDR;
                    end
                    else if (data_len_next == 16'd0)
                    begin
                        answers_next = ans_dec;
                        if (ans_dec == 16'd0)
                        begin
                            res_fire   = 1'b1;
                            res_status = ST_NO_A;
                        end
                        else
                            phase_next = PH_NAME;
                    end
                    else
                        phase_next = PH_RDATA;
                end
            end
            PH_ADDR:
            begin
                addr_next      = {addr_reg[23:0], b};
                field_pos_next = field_pos_reg + FIELD_W'(1);
                if (field_pos_next >= ADDR_BYTES)
                begin
                    res_fire   = 1'b1;
                    res_status = ST_FOUND;
                    res_addr   = addr_next;
                end
            end
            PH_RDATA:
            begin
                data_len_next = data_len_reg - 16'd1;
                if (data_len_next == 16'd0)
                begin
                    answers_next = ans_dec;
                    if (ans_dec == 16'd0)
                    begin
                        res_fire   = 1'b1;
                        res_status = ST_NO_A;
                    end
                    else
                        phase_next = PH_NAME;
                end
            end
            default: ;  // drain: count bytes only
        endcase

        if (!in_prefix)
        begin
            if (res_fire)
            begin
                reported_next = 1'b1;
                phase_next    = PH_DRAIN;
            end
            byte_pos_next = p_inc[POS_W-1:0];
            // last byte of the message: report malformed if nothing went out yet
            if (p_inc >= {1'b0, msg_len_reg})
            begin
                if (!reported_next)
                begin
                    res_fire      = 1'b1;
                    res_status    = ST_MALFORMED;
                    res_addr      = 32'd0;
                    reported_next = 1'b1;
                end
                phase_next    = PH_PREFIX_HI;
                byte_pos_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PREFIX_HI;
            byte_pos_reg  <= '0;
            msg_len_reg   <= '0;
            answers_reg   <= '0;
            flags_reg     <= '0;
            skip_reg      <= '0;
            field_pos_reg <= '0;
            rec_type_reg  <= '0;
            rec_class_reg <= '0;
            data_len_reg  <= '0;
            addr_reg      <= '0;
            reported_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            byte_pos_reg  <= byte_pos_next;
            msg_len_reg   <= msg_len_next;
            answers_reg   <= answers_next;
            flags_reg     <= flags_next;
            skip_reg      <= skip_next;
            field_pos_reg <= field_pos_next;
            rec_type_reg  <= rec_type_next;
            rec_class_reg <= rec_class_next;
            data_len_reg  <= data_len_next;
            addr_reg      <= addr_next;
            reported_reg  <= reported_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qlen_reg <= QLEN_RESET;
        else if (cfg_valid && cfg_ready)
            qlen_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && res_fire)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_fire)
        begin
            out_status_reg <= res_status;
            out_addr_reg   <= res_addr;
            out_flags_reg  <= flags_next;
        end
    end

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_flags_reg, out_addr_reg, out_status_reg};

`ifndef SYNTHESIS
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_fire |=> m_axis_tvalid && m_axis_tdata[2:0] == $past(res_status))
        else $error("result not loaded into output register");

    a_drain_reported: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DRAIN |-> reported_reg)
        else $error("draining a message that has no status");

    a_found_flags: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_fire && res_status == ST_FOUND |=>
            m_axis_tdata[50] && m_axis_tdata[38:35] == 4'd0)
        else $error("address reported with bad header flags");

    a_header_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_PREFIX_LO && !res_fire |=>
            phase_reg == PH_HEADER && byte_pos_reg == '0 && !reported_reg)
        else $error("payload did not start at header byte zero");
`endif

endmodule
